FILE: hw/rtl/pscache_pkg.sv
// Shared types and constants for the pinned segment cache table.
// No dependencies.
`timescale 1ns / 1ps
package pscache_pkg;
   localparam int ENTRIES = 128;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = IDX_W + 1;
   localparam logic signed [15:0] LOCK_MAX = 16'sh7FFF;
   localparam logic signed [15:0] LOCK_MIN = 16'sh8000;

   typedef enum logic [2:0] {
      ST_HIT       = 3'd0,
      ST_FILLED    = 3'd1,
      ST_LOCKED    = 3'd2,
      ST_REL_ZERO  = 3'd3,
      ST_REL_OTHER = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SCAN,
      PH_VICTIM,
      PH_DONE
   } phase_type;

   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // one entry of the table as it moves down the chain
   typedef struct packed {
      logic              valid;
      logic [7:0]        file_id;
      logic [31:0]       offset;
      logic [31:0]       length;
      logic signed [15:0] locks;
   } entry_type;

   // per-cycle instruction to the head of the chain
   typedef struct packed {
      logic              rotate;
      logic              write;
      entry_type         data;
   } chain_ctl_type;
endpackage

FILE: hw/rtl/pinned_segment_cache_table_core.sv
// Top level of the pinned segment cache table: command port, sequencer, entry ring.
// Depends on pscache_pkg and pscache_chain.
`timescale 1ns / 1ps
// Entries live in a ring of cells that rotates one place per cycle while a
// pass runs. The sequencer sees only the head. Every pass is one full
// rotation, so entry 0 is at the head whenever a request starts.
// Steps from the request transfer to the result transfer:
//   - hit, release or all locked: one match pass over all ENTRIES cells,
//     which also picks the round-robin victim, then the DONE phase forms
//     the result.
//   - acquire miss that fills an entry: a second rotation after the match
//     pass writes the victim when it passes the head.
// busy is high from the request transfer until the strobe cycle. A new
// request may be accepted in the strobe cycle. The result is shown for one
// cycle on rsp_valid and cannot be held off. Reset clears every cell of the
// ring.
module pinned_segment_cache_table_core import pscache_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [7:0]        req_file_id,
   input  logic [31:0]       req_offset,
   input  logic [31:0]       req_length,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [6:0]        rsp_slot,
   output logic              rsp_evicted,
   output logic signed [15:0] rsp_lock_count
);
   phase_type phase_ff, phase_in;
   logic [IDX_W-1:0] pos_ff, pos_in;       // index of entry at head
   logic [CNT_W-1:0] cnt_ff, cnt_in;       // cells visited in this pass
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic             cmd_ff;
   logic [7:0]       file_ff;
   logic [31:0]      off_ff, len_ff;
   logic             found_ff, found_in;   // hit or release reaching zero
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic signed [15:0] lk_ff, lk_in;
   logic signed [15:0] cur_lk_ff, cur_lk_in; // count at cursor for all locked
   logic             vic_ok_ff, vic_ok_in;
   logic [IDX_W-1:0] vic_gap_ff, vic_gap_in;
   logic [IDX_W-1:0] vic_slot_ff, vic_slot_in;
   logic             vic_valid_ff, vic_valid_in;
   logic             valid_ff, valid_in;
   status_type       st_ff, st_in;
   logic [IDX_W-1:0] rslot_ff, rslot_in;
   logic             ev_ff, ev_in;
   logic signed [15:0] rlk_ff, rlk_in;

   chain_ctl_type ctl;
   entry_type     head, upd, fill_e;
   logic          match, accept, last, cand, fill_go;
   logic [IDX_W-1:0] gap;                  // ring distance of head from cursor
   logic signed [15:0] inc_v, dec_v;

   pscache_chain u_chain (.clock, .reset, .ctl, .head);

   assign accept = start && !busy;
   assign busy   = (phase_ff != PH_IDLE);
   assign last   = (cnt_ff == CNT_W'(ENTRIES - 1));
   assign match  = head.valid && head.file_id == file_ff && head.offset == off_ff &&
                   head.length >= len_ff;
   assign gap    = pos_ff - cursor_ff;
   assign cand   = head.locks <= 16'sd0 && (!vic_ok_ff || gap < vic_gap_ff);
   assign inc_v  = (head.locks == LOCK_MAX) ? LOCK_MAX :
                   ((head.locks + 16'sd1) <= 16'sd1 ? 16'sd1 : head.locks + 16'sd1);
   assign dec_v  = (head.locks == LOCK_MIN) ? LOCK_MIN : head.locks - 16'sd1;
   assign fill_go = (cmd_ff == CMD_ACQUIRE) && !found_in && vic_ok_in;

   // entry written into the victim slot
   always_comb begin
      fill_e.valid   = 1'b1;
      fill_e.file_id = file_ff;
      fill_e.offset  = off_ff;
      fill_e.length  = len_ff;
      fill_e.locks   = 16'sd1;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE:   if (accept) phase_in = PH_SCAN;
         PH_SCAN:   if (last) phase_in = fill_go ? PH_VICTIM : PH_DONE;
         PH_VICTIM: if (last) phase_in = PH_DONE;
         PH_DONE:   phase_in = PH_IDLE;
         default:   phase_in = PH_IDLE;
      endcase
   end

   // datapath, ring control and result
   always_comb begin
      pos_in = pos_ff; cnt_in = cnt_ff; cursor_in = cursor_ff;
      found_in = found_ff; slot_in = slot_ff; lk_in = lk_ff; cur_lk_in = cur_lk_ff;
      vic_ok_in = vic_ok_ff; vic_gap_in = vic_gap_ff; vic_slot_in = vic_slot_ff;
      vic_valid_in = vic_valid_ff;
      valid_in = 1'b0; st_in = st_ff; rslot_in = rslot_ff; ev_in = ev_ff; rlk_in = rlk_ff;
      upd = head;
      ctl.rotate = 1'b0; ctl.write = 1'b0; ctl.data = head;
      unique case (phase_ff)
         PH_IDLE: begin
            cnt_in = '0; found_in = 1'b0; slot_in = '0; lk_in = '0;
            vic_ok_in = 1'b0; cur_lk_in = '0;
         end
         PH_SCAN: begin
            ctl.rotate = 1'b1;
            pos_in = pos_ff + 1'b1;
            cnt_in = last ? '0 : cnt_ff + 1'b1;
            if (pos_ff == cursor_ff) cur_lk_in = head.locks;
            // track the unlocked entry nearest the cursor in round-robin order
            if (cand) begin
               vic_ok_in = 1'b1; vic_gap_in = gap;
               vic_slot_in = pos_ff; vic_valid_in = head.valid;
            end
            if (!found_ff && match) begin
               if (cmd_ff == CMD_ACQUIRE) begin
                  upd.locks = inc_v; found_in = 1'b1;
                  slot_in = pos_ff; lk_in = inc_v;
               end else begin
                  upd.locks = dec_v;
                  slot_in = pos_ff; lk_in = dec_v;
                  found_in = (dec_v == 16'sd0);
               end
               ctl.write = 1'b1;
            end
            ctl.data = upd;
         end
         PH_VICTIM: begin
            ctl.rotate = 1'b1;
            pos_in = pos_ff + 1'b1;
            cnt_in = last ? '0 : cnt_ff + 1'b1;
            // write the new entry as the victim leaves the head
            if (pos_ff == vic_slot_ff) begin
               ctl.write = 1'b1; ctl.data = fill_e;
               cursor_in = pos_ff + 1'b1;
            end
         end
         PH_DONE: begin
            valid_in = 1'b1;
            ev_in = 1'b0; rslot_in = slot_ff; rlk_in = lk_ff;
            priority if (cmd_ff == CMD_RELEASE) begin
               st_in = found_ff ? ST_REL_ZERO : ST_REL_OTHER;
            end else if (found_ff) begin
               st_in = ST_HIT;
            end else if (vic_ok_ff) begin
               st_in = ST_FILLED; rslot_in = vic_slot_ff; ev_in = vic_valid_ff;
               rlk_in = 16'sd1;
            end else begin
               st_in = ST_LOCKED; rslot_in = cursor_ff; rlk_in = cur_lk_ff;
            end
         end
         default: ;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; pos_ff <= '0; cnt_ff <= '0; cursor_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; cnt_ff <= cnt_in;
         cursor_ff <= cursor_in; valid_ff <= valid_in;
      end
   end

   // hold the request and the working values of the pass
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd; file_ff <= req_file_id;
         off_ff <= req_offset; len_ff <= req_length;
      end
      found_ff <= found_in; slot_ff <= slot_in; lk_ff <= lk_in; cur_lk_ff <= cur_lk_in;
      vic_ok_ff <= vic_ok_in; vic_gap_ff <= vic_gap_in; vic_slot_ff <= vic_slot_in;
      vic_valid_ff <= vic_valid_in;
      st_ff <= st_in; rslot_ff <= rslot_in; ev_ff <= ev_in; rlk_ff <= rlk_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = st_ff;
   assign rsp_slot       = 7'(rslot_ff);
   assign rsp_evicted    = ev_ff;
   assign rsp_lock_count = rlk_ff;

   // no result strobe while a request is in flight
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("busy not raised");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");
endmodule

FILE: hw/rtl/pscache_cell.sv
// One storage cell of the rotating entry chain.
// Depends on pscache_pkg.
`timescale 1ns / 1ps
module pscache_cell import pscache_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type prev_entry,
   output entry_type entry
);
   entry_type entry_ff;

   // take the neighbor's entry on each rotation step
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift) begin
         entry_ff <= prev_entry;
      end
   end

   assign entry = entry_ff;
endmodule

FILE: hw/rtl/pscache_chain.sv
// Ring of ENTRIES cells; the head cell value is presented, modified and fed back.
// Depends on pscache_pkg and pscache_cell.
`timescale 1ns / 1ps
module pscache_chain import pscache_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  chain_ctl_type ctl,
   output entry_type     head
);
   entry_type links [ENTRIES];
   entry_type feed;

   // write back the (possibly updated) head into the tail of the ring
   assign feed = ctl.write ? ctl.data : links[0];

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         if (g == ENTRIES - 1) begin : g_tail
            pscache_cell u_cell (.clock, .reset, .shift(ctl.rotate),
               .prev_entry(feed), .entry(links[g]));
         end else begin : g_body
            pscache_cell u_cell (.clock, .reset, .shift(ctl.rotate),
               .prev_entry(links[g+1]), .entry(links[g]));
         end
      end
   endgenerate

   assign head = links[0];
endmodule

FILE: test/tb_pinned_segment_cache_table_core.sv
// Testbench for pinned_segment_cache_table_core: directed and random acquire/release traffic
// checked against a lock-count table predictor kept in a small scoreboard class.
// Depends on pscache_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_pinned_segment_cache_table_core;
   import pscache_pkg::*;

   localparam int TABLE_SIZE  = 128;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int KEY_POOL    = 24;

   typedef struct {
      status_type        status;
      logic [6:0]        slot;
      logic              evicted;
      logic signed [15:0] lock_count;
   } segment_result_type;

   // lock-count table predictor plus queue of pending expected results
   class segment_table_scoreboard;
      logic [7:0]  seg_file [TABLE_SIZE];
      logic [31:0] seg_offset [TABLE_SIZE];
      logic [31:0] seg_length [TABLE_SIZE];
      bit          seg_valid [TABLE_SIZE];
      int          seg_locks [TABLE_SIZE];
      int          victim_cursor;
      segment_result_type pending_results[$];
      int          error_count;

      function new();
         for (int i = 0; i < TABLE_SIZE; i++) begin
            seg_file[i] = '0;
            seg_offset[i] = '0;
            seg_length[i] = '0;
            seg_valid[i] = 1'b0;
            seg_locks[i] = 0;
         end
         victim_cursor = 0;
         error_count = 0;
      endfunction

      function bit segment_hits(int i, logic [7:0] f, logic [31:0] off, logic [31:0] len);
         return seg_valid[i] && seg_file[i] == f && seg_offset[i] == off &&
                seg_length[i] >= len;
      endfunction

      // predict the result of one accepted transfer and update the table
      function void note_request(logic cmd, logic [7:0] f, logic [31:0] off,
                                 logic [31:0] len);
         segment_result_type r;
         int v;
         int c;
         bit any;
         r.evicted = 1'b0;
         if (cmd == CMD_ACQUIRE) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
               if (segment_hits(i, f, off, len)) begin
                  v = seg_locks[i];
                  if (v < 32767) v++;
                  if (v <= 1) v = 1;
                  seg_locks[i] = v;
                  r.status = ST_HIT;
                  r.slot = 7'(i);
                  r.lock_count = 16'(v);
                  pending_results.push_back(r);
                  return;
               end
            end
            c = victim_cursor;
            for (int n = 0; n < TABLE_SIZE; n++) begin
               if (seg_locks[c] <= 0) begin
                  r.status = ST_FILLED;
                  r.slot = 7'(c);
                  r.evicted = seg_valid[c];
                  r.lock_count = 16'sd1;
                  seg_file[c] = f;
                  seg_offset[c] = off;
                  seg_length[c] = len;
                  seg_valid[c] = 1'b1;
                  seg_locks[c] = 1;
                  victim_cursor = (c + 1) % TABLE_SIZE;
                  pending_results.push_back(r);
                  return;
               end
               c = (c + 1) % TABLE_SIZE;
            end
            r.status = ST_LOCKED;
            r.slot = 7'(victim_cursor);
            r.lock_count = 16'(seg_locks[victim_cursor]);
            pending_results.push_back(r);
         end else begin
            any = 1'b0;
            r.status = ST_REL_OTHER;
            r.slot = '0;
            r.lock_count = '0;
            for (int i = 0; i < TABLE_SIZE; i++) begin
               if (segment_hits(i, f, off, len)) begin
                  v = seg_locks[i];
                  if (v > -32768) v--;
                  seg_locks[i] = v;
                  any = 1'b1;
                  r.slot = 7'(i);
                  r.lock_count = 16'(v);
                  if (v == 0) begin
                     r.status = ST_REL_ZERO;
                     pending_results.push_back(r);
                     return;
                  end
               end
            end
            pending_results.push_back(r);
         end
      endfunction

      // compare one strobed result with the oldest expectation
      function void check_result(logic [2:0] status, logic [6:0] slot, logic evicted,
                                 logic signed [15:0] lock_count);
         segment_result_type e;
         if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d slot %0d", status, slot);
            error_count++;
            return;
         end
         e = pending_results.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, status);
            error_count++;
         end
         if (slot !== e.slot) begin
            $error("slot: expected %0d actual %0d", e.slot, slot);
            error_count++;
         end
         if (evicted !== e.evicted) begin
            $error("evicted: expected %0d actual %0d", e.evicted, evicted);
            error_count++;
         end
         if (lock_count !== e.lock_count) begin
            $error("lock_count: expected %0d actual %0d", e.lock_count, lock_count);
            error_count++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_cmd;
   logic [7:0]        req_file_id;
   logic [31:0]       req_offset;
   logic [31:0]       req_length;
   logic              rsp_valid;
   logic [2:0]        rsp_status;
   logic [6:0]        rsp_slot;
   logic              rsp_evicted;
   logic signed [15:0] rsp_lock_count;

   segment_table_scoreboard table_sb;
   logic [7:0]  pool_file [KEY_POOL];
   logic [31:0] pool_offset [KEY_POOL];
   bit          quiet_sender;

   pinned_segment_cache_table_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_file_id(req_file_id), .req_offset(req_offset),
      .req_length(req_length), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_slot(rsp_slot), .rsp_evicted(rsp_evicted), .rsp_lock_count(rsp_lock_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // check every strobed result
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         table_sb.check_result(rsp_status, rsp_slot, rsp_evicted, rsp_lock_count);
   end

   // end the run if it hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   // drive one transfer; starts and ends at a falling edge
   task automatic send_segment_op(logic cmd, logic [7:0] f, logic [31:0] off,
                                  logic [31:0] len);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 9);
      start = 1'b0;
      repeat (gap) @(negedge clock);
      start = 1'b1;
      req_cmd = cmd;
      req_file_id = f;
      req_offset = off;
      req_length = len;
      while (busy) @(negedge clock);
      @(posedge clock);
      table_sb.note_request(cmd, f, off, len);
      @(negedge clock);
      start = 1'b0;
   endtask

   // random transfer on a key from the pool, lengths drawn near 0, 64 or the maximum, or at random
   task automatic send_pool_op();
      int k;
      logic [31:0] len;
      k = $urandom_range(0, KEY_POOL - 1);
      case ($urandom_range(0, 3))
         0: len = $urandom_range(0, 3);
         1: len = 32'd64 + $urandom_range(0, 2);
         2: len = 32'hFFFF_FFFF - $urandom_range(0, 1);
         default: len = $urandom();
      endcase
      send_segment_op(logic'($urandom_range(0, 1)), pool_file[k], pool_offset[k], len);
   endtask

   initial begin
      logic [7:0]  burst_file [$];
      logic [31:0] burst_offset [$];
      int done_items;
      table_sb = new();
      quiet_sender = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_ACQUIRE;
      req_file_id = '0;
      req_offset = '0;
      req_length = '0;
      for (int k = 0; k < KEY_POOL; k++) begin
         pool_file[k] = (k < 2) ? {8{k[0]}} : 8'($urandom());
         pool_offset[k] = (k < 2) ? {32{k[0]}} : ((k < 12) ? 32'(k) : $urandom());
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, hit, length compare, release cases, negative counts
      send_segment_op(CMD_RELEASE, 8'h00, 32'h0, 32'h0);
      send_segment_op(CMD_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_segment_op(CMD_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 32'h0);
      send_segment_op(CMD_ACQUIRE, 8'h00, 32'h0, 32'h0);
      send_segment_op(CMD_ACQUIRE, 8'h00, 32'h0, 32'h1);
      send_segment_op(CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 32'h5);
      send_segment_op(CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 32'h5);
      send_segment_op(CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 32'h5);
      send_segment_op(CMD_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 32'h1);
      send_segment_op(CMD_RELEASE, 8'h00, 32'h0, 32'h0);
      send_segment_op(CMD_RELEASE, 8'h00, 32'h0, 32'h0);
      send_segment_op(CMD_RELEASE, 8'h00, 32'h0, 32'h0);
      send_segment_op(CMD_RELEASE, 8'h5A, 32'hA5A5_A5A5, 32'h0);
      send_segment_op(CMD_ACQUIRE, 8'hA5, 32'h5A5A_5A5A, 32'h8000_0000);
      send_segment_op(CMD_ACQUIRE, 8'hA5, 32'h5A5A_5A5A, 32'h8000_0001);
      send_segment_op(CMD_RELEASE, 8'hA5, 32'h5A5A_5A5A, 32'h0);

      // random: pool traffic with fill bursts that can lock the whole table
      done_items = 16;
      while (done_items < 750) begin
         if ($urandom_range(0, 3) == 0) quiet_sender = ~quiet_sender;
         repeat ($urandom_range(40, 120)) begin
            if (done_items < 750) begin
               send_pool_op();
               done_items++;
            end
         end
         if ($urandom_range(0, 1) == 0 && done_items < 480) begin
            burst_file.delete();
            burst_offset.delete();
            repeat ($urandom_range(125, 134)) begin
               burst_file.push_back(8'($urandom()));
               burst_offset.push_back($urandom());
               send_segment_op(CMD_ACQUIRE, burst_file[$], burst_offset[$], $urandom());
               done_items++;
            end
            while (burst_file.size() > 0) begin
               send_segment_op(CMD_RELEASE, burst_file.pop_front(), burst_offset.pop_front(),
                               32'h0);
               done_items++;
            end
         end
      end

      // drain
      while (table_sb.pending_results.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (table_sb.error_count == 0 && table_sb.pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
